// ===== hw/rtl/rotary_encoder_percent_control_defines.svh =====
// Assertion macros for the rotary encoder percent control block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ROTARY_ENCODER_PERCENT_CONTROL_DEFINES_SVH
`define ROTARY_ENCODER_PERCENT_CONTROL_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rec_pkg.sv =====
// Shared types, register codes and the duty lookup table.
// No dependencies; used by the interface users, lanes, merge stage and top.
`timescale 1ns / 1ps
package rec_pkg;

    localparam int PCT_W  = 7;
    localparam int DUTY_W = 8;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERCENT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERCENT = 8'd3;

    localparam logic [7:0]       RST_DEBOUNCE_MS = 8'd5;
    localparam logic [PCT_W-1:0] RST_STEP_SIZE   = 7'd5;
    localparam logic [PCT_W-1:0] RST_MIN_PERCENT = 7'd0;
    localparam logic [PCT_W-1:0] RST_MAX_PERCENT = 7'd100;

    localparam int DUTY_FULL  = 255;
    localparam int PCT_FULL   = 100;
    localparam int DUTY_DEPTH = 2 ** PCT_W;

    typedef struct packed {
        logic              clk_a;
        logic              dir_a;
        logic              button_a;
        logic              clk_b;
        logic              dir_b;
        logic              button_b;
        logic [TIME_W-1:0] now_ms;
        logic              write_enable;
        logic              write_channel;
        logic [7:0]        write_value;
    } t_in_item;

    typedef struct packed {
        logic [PCT_W-1:0]  percent_a;
        logic [PCT_W-1:0]  percent_b;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]       debounce_ms;
        logic [PCT_W-1:0] step_size;
        logic [PCT_W-1:0] min_percent;
        logic [PCT_W-1:0] max_percent;
    } t_cfg;

    // one channel's pin sample
    typedef struct packed {
        logic clk;
        logic dt;
        logic btn;
    } t_lane_sample;

    typedef logic [DUTY_W-1:0] t_duty_tab [DUTY_DEPTH];

    // percent*255/100, saturated; evaluated at elaboration only
    function automatic t_duty_tab f_duty_table();
        t_duty_tab tab;
        int        d;
        for (int i = 0; i < DUTY_DEPTH; i++) begin
            d = (i * DUTY_FULL) / PCT_FULL;
            tab[i] = (d > DUTY_FULL) ? DUTY_W'(DUTY_FULL) : DUTY_W'(d);
        end
        return tab;
    endfunction

    localparam t_duty_tab DUTY_TAB = f_duty_table();

endpackage

// ===== hw/rtl/rec_stream_if.sv =====
// Valid/ready channel carrying one payload item of type T.
// Depends on nothing; payload types come from rec_pkg at instantiation.
`timescale 1ns / 1ps
interface rec_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rec_lane.sv =====
// One encoder channel: debounce, saturating step, button clear, direct write.
// Depends on rec_pkg.
`timescale 1ns / 1ps
module rec_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  rec_pkg::t_lane_sample          i_sample,
    input  logic [rec_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                           i_wr_en,
    input  logic [7:0]                     i_wr_value,
    input  rec_pkg::t_cfg                  i_cfg,
    output logic [rec_pkg::PCT_W-1:0]      o_next_pct,
    output logic [rec_pkg::PCT_W-1:0]      o_pct
);
    logic [rec_pkg::PCT_W-1:0]  r_pct, n_pct;
    logic                       r_acc_clk;
    logic                       r_smp_clk;
    logic [rec_pkg::TIME_W-1:0] r_last_ms;
    logic                       r_prev_btn;

    logic [rec_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_pass;
    logic                       w_step;
    logic [rec_pkg::PCT_W:0]    w_sum;
    logic [rec_pkg::PCT_W:0]    w_floor;
    logic [rec_pkg::PCT_W-1:0]  w_enc_pct;

    assign w_elapsed = i_now_ms - r_last_ms;
    assign w_pass    = (i_sample.clk != r_smp_clk) &&
                       (w_elapsed > {{(rec_pkg::TIME_W-8){1'b0}}, i_cfg.debounce_ms});
    assign w_step    = w_pass && (i_sample.clk != r_acc_clk);
    assign w_sum     = {1'b0, r_pct} + {1'b0, i_cfg.step_size};
    assign w_floor   = {1'b0, i_cfg.step_size} + {1'b0, i_cfg.min_percent};

    always_comb begin
        w_enc_pct = r_pct;
        if (w_step) begin
            if (i_sample.dt != i_sample.clk) begin
                // clockwise
                if (r_pct < i_cfg.max_percent) begin
                    w_enc_pct = (w_sum > {1'b0, i_cfg.max_percent}) ?
                                i_cfg.max_percent : w_sum[rec_pkg::PCT_W-1:0];
                end
            end else begin
                if (r_pct > i_cfg.min_percent) begin
                    w_enc_pct = ({1'b0, r_pct} < w_floor) ?
                                i_cfg.min_percent : (r_pct - i_cfg.step_size);
                end
            end
        end

        n_pct = w_enc_pct;
        if (!i_sample.btn && r_prev_btn) begin
            n_pct = '0;
        end
        if (i_wr_en) begin
            n_pct = (i_wr_value > {1'b0, i_cfg.max_percent}) ?
                    i_cfg.max_percent : i_wr_value[rec_pkg::PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct      <= '0;
            r_acc_clk  <= 1'b0;
            r_smp_clk  <= 1'b0;
            r_last_ms  <= '0;
            r_prev_btn <= 1'b1;
        end else if (i_accept) begin
            r_pct      <= n_pct;
            r_smp_clk  <= i_sample.clk;
            r_prev_btn <= i_sample.btn;
            if (w_pass) begin
                r_last_ms <= i_now_ms;
            end
            if (w_step) begin
                r_acc_clk <= i_sample.clk;
            end
        end
    end

    assign o_next_pct = n_pct;
    assign o_pct      = r_pct;
endmodule

// ===== hw/rtl/rec_merge.sv =====
// Merge stage: gathers lane values into a two-entry result queue, adds duty.
// Depends on rec_pkg and rec_stream_if.
`timescale 1ns / 1ps
module rec_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [rec_pkg::PCT_W-1:0] i_pct_a,
    input  logic [rec_pkg::PCT_W-1:0] i_pct_b,
    output logic                      o_full,
    rec_stream_if.source              o_out_ch
);
    localparam int DEPTH = 2;

    logic [rec_pkg::PCT_W-1:0] r_q_a [DEPTH];
    logic [rec_pkg::PCT_W-1:0] r_q_b [DEPTH];
    logic                      r_wr_ptr;
    logic                      r_rd_ptr;
    logic [1:0]                r_count, n_count;
    logic                      w_pop;
    logic [rec_pkg::PCT_W-1:0] w_head_a;
    logic [rec_pkg::PCT_W-1:0] w_head_b;

    assign w_pop  = o_out_ch.valid && o_out_ch.ready;
    assign o_full = (r_count == 2'(DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q_a[r_wr_ptr] <= i_pct_a;
            r_q_b[r_wr_ptr] <= i_pct_b;
        end
    end

    assign w_head_a = r_q_a[r_rd_ptr];
    assign w_head_b = r_q_b[r_rd_ptr];

    assign o_out_ch.valid          = (r_count != 2'd0);
    assign o_out_ch.data.percent_a = w_head_a;
    assign o_out_ch.data.percent_b = w_head_b;
    assign o_out_ch.data.duty_a    = rec_pkg::DUTY_TAB[w_head_a];
    assign o_out_ch.data.duty_b    = rec_pkg::DUTY_TAB[w_head_b];
endmodule

// ===== hw/rtl/rotary_encoder_percent_control.sv =====
// Top level: config registers, encoder lanes and the result merge stage.
// Depends on rec_pkg, rec_stream_if, rec_lane, rec_merge and the defines header.
//
//  channel    dir   payload                     handshake
//  i_in_ch    in    rec_pkg::t_in_item          valid/ready
//  o_out_ch   out   rec_pkg::t_out_item         valid/ready
//  i_cfg_ch   in    rec_pkg::t_cfg_wr           valid/ready, always ready
//
// One item per cycle while the queue is not full: each lane updates its state
// in the accept cycle, a 32-bit elapsed-time compare feeding a saturating add sets the cycle.
// Results are registered into a two-entry queue that feeds the output.
// Input stalls only when both queue entries wait on the output side.
// Synchronous active-low reset restores config defaults and channel state.
`timescale 1ns / 1ps
`include "rotary_encoder_percent_control_defines.svh"
module rotary_encoder_percent_control #(
    parameter int CHANNELS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rec_stream_if.sink    i_in_ch,
    rec_stream_if.source  o_out_ch,
    rec_stream_if.sink    i_cfg_ch
);
    localparam int MAX_LANES = 2;

    rec_pkg::t_cfg r_cfg;
    logic          w_accept;
    logic          w_full;

    rec_pkg::t_lane_sample     w_sample   [MAX_LANES];
    logic                      w_wr_en    [MAX_LANES];
    logic [rec_pkg::PCT_W-1:0] w_next_pct [MAX_LANES];
    logic [rec_pkg::PCT_W-1:0] w_pct      [MAX_LANES];

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= rec_pkg::RST_DEBOUNCE_MS;
            r_cfg.step_size   <= rec_pkg::RST_STEP_SIZE;
            r_cfg.min_percent <= rec_pkg::RST_MIN_PERCENT;
            r_cfg.max_percent <= rec_pkg::RST_MAX_PERCENT;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.data.index)
                rec_pkg::CFG_DEBOUNCE_MS: r_cfg.debounce_ms <= i_cfg_ch.data.value;
                rec_pkg::CFG_STEP_SIZE:
                    r_cfg.step_size <= i_cfg_ch.data.value[rec_pkg::PCT_W-1:0];
                rec_pkg::CFG_MIN_PERCENT:
                    r_cfg.min_percent <= i_cfg_ch.data.value[rec_pkg::PCT_W-1:0];
                rec_pkg::CFG_MAX_PERCENT:
                    r_cfg.max_percent <= i_cfg_ch.data.value[rec_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in_ch.ready = !w_full;
    assign w_accept      = i_in_ch.valid && !w_full;

    assign w_sample[0] = '{clk: i_in_ch.data.clk_a, dt: i_in_ch.data.dir_a,
                           btn: i_in_ch.data.button_a};
    assign w_sample[1] = '{clk: i_in_ch.data.clk_b, dt: i_in_ch.data.dir_b,
                           btn: i_in_ch.data.button_b};

    for (genvar c = 0; c < MAX_LANES; c++) begin : g_lane
        assign w_wr_en[c] = i_in_ch.data.write_enable &&
                            (i_in_ch.data.write_channel == 1'(c));
        if (c < CHANNELS) begin : g_on
            rec_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_accept   (w_accept),
                .i_sample   (w_sample[c]),
                .i_now_ms   (i_in_ch.data.now_ms),
                .i_wr_en    (w_wr_en[c]),
                .i_wr_value (i_in_ch.data.write_value),
                .i_cfg      (r_cfg),
                .o_next_pct (w_next_pct[c]),
                .o_pct      (w_pct[c])
            );
        end else begin : g_off
            // absent channel reads as zero
            assign w_next_pct[c] = '0;
            assign w_pct[c]      = '0;
        end
    end

    rec_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_pct_a  (w_next_pct[0]),
        .i_pct_b  (w_next_pct[1]),
        .o_full   (w_full),
        .o_out_ch (o_out_ch)
    );

    `ASSERT_SAME_CYCLE(a_stall_has_result, i_clk, i_rst_n, !i_in_ch.ready, o_out_ch.valid)
    `ASSERT_NEXT_CYCLE(a_accept_gives_result, i_clk, i_rst_n, w_accept, o_out_ch.valid)
    `ASSERT_NEXT_CYCLE(a_zero_write_lands, i_clk, i_rst_n, w_accept && w_wr_en[0] && (i_in_ch.data.write_value == 8'd0), w_pct[0] == '0)
endmodule
